>>> sv/ewma_zscore_normalizer_macros.svh
// assertion macros for the normalizer
`ifndef EWMA_ZSCORE_NORMALIZER_MACROS_SVH
`define EWMA_ZSCORE_NORMALIZER_MACROS_SVH
`ifndef SYNTHESIS
`define EZN_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("label");
`define EZN_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("label");
`else
`define EZN_ASSERT_IMP(label, clk, rst, a, c)
`define EZN_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

>>> sv/ezn_pkg.sv
// shared constants and types of the normalizer
`default_nettype none
package ezn_pkg;
  localparam int CHANNELS_DEF = 2;
  localparam logic [15:0] ALPHA_RESET = 16'd655;
  localparam logic [31:0] MEAN_RESET = 32'h0001_0000;
  localparam logic [63:0] VAR_RESET = 64'h0000_0001_0000_0000;
  localparam logic [15:0] SCORE_ONE = 16'd16384;
  typedef struct packed {
    logic start;
    logic [63:0] radicand;
  } sqrt_req_t;
  typedef struct packed {
    logic start;
    logic [46:0] num;
    logic [31:0] den;
  } div_req_t;
endpackage
`default_nettype wire

>>> sv/ewma_zscore_normalizer.sv
// top level: per-channel ewma mean and variance with z-score output
// Usage: requests enter on in_valid/in_stall with channel and sample (Q16.16).
// One score (signed Q1.14, clamped to +/-1) leaves per request on out_valid/
// out_stall in request order. alpha is written from cfg_data on cfg_valid/cfg_ready
// while idle; reset value 655.
// Steps from acceptance to out_valid, in order: ram read, mean multiply and
// round, differences, variance product and blend, sqrt start, a 32-step square
// root, handover and a 15-step divider. One request is in flight at a time;
// in_stall is high from acceptance until the score is taken from the output
// register, so a new request is taken only after the previous score has left.
// A stalled output holds its score and delays the next request.
// Reset: in_stall is high and cfg_ready low while rst is high; both channels
// read as mean 1.0 and variance 1.0 via valid bits, alpha returns to 655;
// no clearing pass is needed.
`default_nettype none
`include "ewma_zscore_normalizer_macros.svh"
module ewma_zscore_normalizer #(
  parameter int CHANNELS = ezn_pkg::CHANNELS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [0:0]         channel,
  input  wire logic signed [31:0] sample,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      score,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data
);
  import ezn_pkg::*;
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_READ = 4'd1, S_M1 = 4'd2, S_M2 = 4'd3,
    S_V1 = 4'd4, S_V2 = 4'd5, S_V3 = 4'd6, S_SQ = 4'd7, S_SQW = 4'd8,
    S_DV = 4'd9, S_DVW = 4'd10, S_OUT = 4'd11, S_V4 = 4'd12;

  logic [3:0]  state;
  logic [15:0] alpha;
  logic [CHANNELS-1:0] vld;
  logic [AW-1:0] ch;
  logic        ch_ok;
  logic signed [31:0] x;
  logic signed [31:0] om;
  logic signed [31:0] nm;
  logic [63:0] ov;
  logic [63:0] nv;
  logic [16:0] wold;
  logic signed [49:0] pa;
  logic signed [49:0] pb;
  logic [32:0] m1;
  logic [31:0] m2;
  logic        neg;
  logic [63:0] p;
  logic [48:0] lo_a, lo_b, hi_a, hi_b;
  logic [31:0] s;
  logic [15:0] q;
  logic        we;
  logic [31:0] mean_rd;
  logic [63:0] var_rd;
  sqrt_req_t   sq_req;
  div_req_t    dv_req;
  logic        sq_done, dv_done;
  logic [31:0] sq_root;
  logic [15:0] dv_q;

  assign wold = 17'h10000 - {1'b0, alpha};
  assign in_stall = rst || (state != S_IDLE);
  assign cfg_ready = !rst && (state == S_IDLE) && !in_valid;
  assign out_valid = (state == S_OUT);

  ezn_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_mean (
    .clk(clk), .we(we), .addr(ch), .wdata(nm), .rdata(mean_rd));
  ezn_ram #(.WIDTH(64), .DEPTH(CHANNELS)) u_var (
    .clk(clk), .we(we), .addr(ch), .wdata(nv), .rdata(var_rd));
  ezn_sqrt u_sqrt (.clk(clk), .rst(rst), .req(sq_req), .done(sq_done), .root(sq_root));
  ezn_div u_div (.clk(clk), .rst(rst), .req(dv_req), .done(dv_done), .quot(dv_q));

  assign sq_req.start = (state == S_SQ);
  assign sq_req.radicand = nv;
  assign dv_req.start = (state == S_DV);
  assign dv_req.num = {m1[32:0], 14'd0};
  assign dv_req.den = s;
  assign we = (state == S_V4) && ch_ok;

  logic signed [50:0] msum;
  logic [33:0] d1, d2;
  assign msum = 51'(pa) + 51'(pb) + 51'sd32768;
  always_comb begin
    d1 = 34'(signed'(x)) - 34'(signed'(nm));
    d2 = 34'(signed'(x)) - 34'(signed'(om));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      alpha <= ALPHA_RESET;
      vld   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            alpha <= cfg_data;
          end
          if (in_valid) begin
            ch    <= AW'(channel);
            ch_ok <= ({31'd0, channel} < 32'(CHANNELS));
            x     <= sample;
            state <= S_READ;
          end
        end
        S_READ: state <= S_M1;
        S_M1: begin
          om <= vld[ch] ? signed'(mean_rd) : signed'(MEAN_RESET);
          ov <= vld[ch] ? var_rd : VAR_RESET;
          state <= S_M2;
        end
        S_M2: begin
          pa <= signed'({1'b0, wold}) * om;
          pb <= signed'({1'b0, alpha}) * x;
          state <= S_V1;
        end
        S_V1: begin
          nm <= 32'(msum >>> 16);
          state <= S_V2;
        end
        S_V2: begin
          // both differences stay below 2^32 in magnitude
          m1  <= d1[33] ? 33'(-d1) : 33'(d1);
          m2  <= d2[33] ? 32'(-d2) : 32'(d2);
          neg <= d1[33];
          state <= S_V3;
        end
        S_V3: begin
          p <= 64'(m1[31:0]) * 64'(m2);
          state <= S_V4;
        end
        S_V4: state <= S_SQ;
        S_SQ: state <= S_SQW;
        S_SQW: if (sq_done) begin
          s <= sq_root;
          state <= S_DV;
        end
        S_DV: state <= S_DVW;
        S_DVW: if (dv_done) begin
          if (m1 == 33'd0) q <= '0;
          else if (s == 32'd0) q <= SCORE_ONE;
          else q <= dv_q;
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (we) vld[ch] <= 1'b1;
    end
  end

  // variance blend from the registered product
  assign lo_a = 49'(wold) * 49'(ov[31:0]);
  assign lo_b = 49'(alpha) * 49'(p[31:0]);
  assign hi_a = 49'(wold) * 49'(ov[63:32]);
  assign hi_b = 49'(alpha) * 49'(p[63:32]);
  logic [49:0] lo_s;
  logic [49:0] hi_s;
  assign lo_s = 50'(lo_a) + 50'(lo_b) + 50'd32768;
  assign hi_s = 50'(hi_a) + 50'(hi_b);
  always_comb begin
    nv = (64'(hi_s) << 16) + 64'(lo_s >> 16);
  end

  always_comb begin
    if (!ch_ok) score = '0;
    else if (neg) score = signed'(16'(17'h10000 - {1'b0, q}));
    else score = signed'(q);
  end

  `EZN_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(score))
  `EZN_ASSERT_IMP(a_one_busy, clk, rst, state != S_IDLE, in_stall)
  `EZN_ASSERT_IMP(a_cfg_idle, clk, rst, cfg_ready, state == S_IDLE)
endmodule
`default_nettype wire

>>> sv/ezn_ram.sv
// generic single-port ram with registered read
`default_nettype none
module ezn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                            wdata,
  output logic      [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> sv/ezn_sqrt.sv
// iterative 64-bit integer square root, one result bit a cycle
`default_nettype none
module ezn_sqrt
  import ezn_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire sqrt_req_t req,
  output logic           done,
  output logic [31:0]    root
);
  logic [63:0] rem;
  logic [63:0] rt;
  logic [63:0] bitv;
  logic        busy;
  logic [63:0] trial;
  assign trial = rt + bitv;
  assign root = rt[31:0];
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem  <= req.radicand;
        rt   <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          rt  <= (rt >> 1) + bitv;
        end else begin
          rt <= rt >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/ezn_div.sv
// restoring divider, quotient saturating above one in q1.14
`default_nettype none
module ezn_div
  import ezn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output logic          done,
  output logic [15:0]   quot
);
  // only 15 quotient bits matter: anything above 16384 clamps
  logic [46:0] rem;
  logic [31:0] den;
  logic [14:0] q;
  logic [3:0]  cnt;
  logic        busy;
  logic        big;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        den  <= req.den;
        q    <= '0;
        cnt  <= 4'd14;
        // num >= den*2^15 means quotient above the clamp
        big  <= (req.num >> 15) >= {15'd0, req.den};
        rem  <= req.num;
      end else if (busy) begin
        if ((rem >> cnt) >= {15'd0, den}) begin
          rem <= rem - ({15'd0, den} << cnt);
          q[cnt] <= 1'b1;
        end
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 4'd1;
        end
      end
    end
  end
  always_comb begin
    if (big || q > SCORE_ONE[14:0]) begin
      quot = SCORE_ONE;
    end else begin
      quot = {1'b0, q};
    end
  end
endmodule
`default_nettype wire

>>> bench/ezn_checker.sv
// checker: watches the request, result and config channels and predicts each score
`default_nettype none
module ezn_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [0:0]         channel,
  input  wire logic signed [31:0] sample,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [15:0] score,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [15:0]        cfg_data,
  output int                      fail_count,
  output int                      pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] mean_q [2];
  logic [63:0]        var_q [2];
  logic [15:0]        alpha_q;
  logic [15:0]        score_queue [$];

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] rem, root, bitv;
    rem = v;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // updates one channel's mean and variance and gives the clamped score
  function automatic logic [15:0] update_score(input logic [0:0] ch,
                                               input logic signed [31:0] x);
    logic signed [63:0] xo, old_m, new_m, d1, d2;
    logic [63:0] w_new, w_old, m1, m2, s, q, lo, hi, p, v;
    logic signed [95:0] acc;
    xo = x;
    w_new = alpha_q;
    w_old = 64'd65536 - w_new;
    old_m = mean_q[ch];
    acc = $signed({32'd0, w_old}) * old_m + $signed({32'd0, w_new}) * xo + 96'sd32768;
    new_m = acc >>> 16;
    d1 = xo - new_m;
    d2 = xo - old_m;
    m1 = d1 < 0 ? -d1 : d1;
    m2 = d2 < 0 ? -d2 : d2;
    p = m1 * m2;
    v = var_q[ch];
    lo = w_old * v[31:0] + w_new * p[31:0] + 64'd32768;
    hi = w_old * v[63:32] + w_new * p[63:32];
    v = (hi << 16) + (lo >> 16);
    mean_q[ch] = new_m[31:0];
    var_q[ch] = v;
    s = floor_root(v);
    if (m1 == 0) q = 0;
    else if (s == 0) q = 16384;
    else begin
      q = (m1 << 14) / s;
      if (q > 16384) q = 16384;
    end
    return d1 < 0 ? 16'(17'h10000 - q[16:0]) : q[15:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      mean_q[0] = 32'sh0001_0000;
      mean_q[1] = 32'sh0001_0000;
      var_q[0] = 64'h1_0000_0000;
      var_q[1] = 64'h1_0000_0000;
      alpha_q = 16'd655;
      score_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) alpha_q = cfg_data;
      if (in_valid && !in_stall) score_queue.push_back(update_score(channel, sample));
      if (out_valid && !out_stall) begin
        if (score_queue.size() == 0) begin
          report_mismatch($sformatf("score %0d with no request waiting", score));
        end else if (score !== score_queue[0]) begin
          report_mismatch($sformatf("score %0d, predicted %0d", score,
                                    $signed(score_queue[0])));
          void'(score_queue.pop_front());
        end else begin
          void'(score_queue.pop_front());
        end
      end
    end
    pending_count = score_queue.size();
  end
endmodule
`default_nettype wire

>>> bench/tb.sv
// testbench top: stimulus, idling and stalling phases and the verdict for the normalizer
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [0:0] channel = 0;
  logic signed [31:0] sample = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [15:0] score;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [15:0] cfg_data = 0;
  int fail_count, pending_count;
  int send_idle_pct = 0, recv_stall_pct = 0;

  ewma_zscore_normalizer i_dut (.*);

  ezn_checker i_checker (.*);

  initial forever #6 clk = ~clk;

  initial begin
    #20ms;
    $display("ewma_zscore_normalizer regression: fail");
    $finish;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // valid stays high into the next request unless the sender idles
  task automatic send_request(input logic [0:0] ch, input logic signed [31:0] x);
    channel <= ch;
    sample <= x;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  task automatic write_alpha(input logic [15:0] a);
    in_valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_data <= a;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic signed [31:0] rand_sample(input logic signed [31:0] centre);
    case ($urandom_range(3))
      0: return $urandom;
      1: return centre + $signed($urandom_range(65535)) - 32768;
      2: return centre + $signed($urandom_range(32'h3ff_ffff)) - 32'sh1ff_ffff;
      default: return centre;
    endcase
  endfunction

  localparam logic [15:0] ALPHAS [6] = '{16'd1, 16'd65535, 16'd32768, 16'd655,
                                         16'd6554, 16'd200};

  initial begin
    logic signed [31:0] centre;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, equal-to-mean and repeated samples driving variance down
    send_request(1'b0, 32'sh0001_0000);
    send_request(1'b1, 32'sh7fff_ffff);
    send_request(1'b1, 32'sh8000_0000);
    send_request(1'b0, 0);
    send_request(1'b0, -1);
    send_request(1'b1, 32'sh0001_0000);
    write_alpha(16'd65535);
    for (int i = 0; i < 6; i++) send_request(i[0], 32'sh0003_0000);
    send_request(1'b0, 32'sh0003_0001);
    send_request(1'b1, 32'sh0002_ffff);
    write_alpha(16'd1);
    send_request(1'b0, 32'sh7fff_ffff);
    send_request(1'b1, 32'sh8000_0000);
    for (int ph = 0; ph < 24; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      write_alpha(ALPHAS[ph % 6]);
      centre = $urandom;
      for (int i = 0; i < 25; i++) send_request(1'($urandom_range(1)), rand_sample(centre));
    end
    in_valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("ewma_zscore_normalizer regression: pass");
    else $display("ewma_zscore_normalizer regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
+incdir+sv
sv/ezn_pkg.sv
sv/ezn_ram.sv
sv/ezn_sqrt.sv
sv/ezn_div.sv
sv/ewma_zscore_normalizer.sv
bench/ezn_checker.sv
bench/tb.sv
